>>> hdl/dsc_pkg.sv
// shared types, constants and helper functions for the day serial to civil date unit
`default_nettype none

package dsc_pkg;

  // calendar constants, day 0 of the rebased count is 0000-01-01
  localparam int EPOCH_OFFSET  = 693961;
  localparam int DAYS_400Y     = 146097;
  localparam int DAYS_100Y     = 36524;
  localparam int DAYS_4Y       = 1461;
  localparam int DAYS_YEAR     = 365;
  localparam int LAST_DAY      = 2958463;

  // time of day constants
  localparam int MS_PER_DAY    = 86400000;
  localparam int MS_PER_HOUR   = 3600000;
  localparam int MS_PER_MINUTE = 60000;
  localparam int MS_PER_SECOND = 1000;

  typedef struct packed {
    logic [21:0] day_number;
    logic [26:0] ms_of_day;
  } dsc_in_t;

  typedef struct packed {
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day_of_month;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [9:0]  millisecond;
    logic        leap_year;
    logic [2:0]  weekday;
    logic        out_of_range;
  } dsc_out_t;

  typedef struct packed {
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day_of_month;
    logic        leap_year;
  } date_t;

  typedef struct packed {
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [9:0]  millisecond;
  } tod_t;

  // one-based position of the top set bit in a thermometer code, 0 when empty
  function automatic logic [6:0] therm_idx(input logic [63:0] t);
    logic [64:0] te;
    logic [6:0]  q;
    te = {1'b0, t};
    q  = '0;
    for (int k = 0; k < 64; k++) begin
      if (te[k] && !te[k+1]) q = q | 7'(k + 1);
    end
    return q;
  endfunction

  // first day of year of month index (0 is january), shifted by leap day
  function automatic logic [8:0] month_start(input logic [3:0] idx, input logic leap);
    logic [8:0] s;
    case (idx)
      4'd0:    s = 9'd0;
      4'd1:    s = 9'd31;
      4'd2:    s = 9'd59;
      4'd3:    s = 9'd90;
      4'd4:    s = 9'd120;
      4'd5:    s = 9'd151;
      4'd6:    s = 9'd181;
      4'd7:    s = 9'd212;
      4'd8:    s = 9'd243;
      4'd9:    s = 9'd273;
      4'd10:   s = 9'd304;
      4'd11:   s = 9'd334;
      default: s = 9'd0;
    endcase
    if (leap && (idx >= 4'd2)) s = s + 9'd1;
    return s;
  endfunction

endpackage

`default_nettype wire

>>> hdl/dsc_date_path.sv
// date pipeline: rebased day count to year, month, day of month and leap flag
`default_nettype none

module dsc_date_path (
  input  wire logic          clk,
  input  wire logic          en,
  input  wire logic [21:0]   day_rebased,
  output dsc_pkg::date_t     date
);
  import dsc_pkg::*;

  // 400-year split: compare bank, then subtract
  logic [23:0] t400_nxt, t400_r;
  logic [21:0] d2_r;
  logic [4:0]  q400;
  logic [17:0] r3_nxt, r3_r;
  logic [13:0] yr3_nxt, yr3_r;

  // century split
  logic [2:0]  tc_nxt, tc_r;
  logic [17:0] r4_r;
  logic [13:0] yr4_r;
  logic [1:0]  cent;
  logic [15:0] f5_nxt, f5_r;
  logic        cnz5_r;
  logic [13:0] yr5_nxt, yr5_r;

  // 4-year split
  logic [23:0] t4_nxt, t4_r;
  logic [15:0] f6_r;
  logic        cnz6_r;
  logic [13:0] yr6_r;
  logic [4:0]  q4;
  logic        short_span;
  logic [10:0] rem7_nxt, rem7_r;
  logic        lspan7_r;
  logic [13:0] yr7_nxt, yr7_r;

  // single-year split
  logic [2:0]  ty_nxt, ty_r;
  logic [10:0] rem8_r;
  logic        lspan8_r;
  logic [13:0] yr8_r;
  logic [1:0]  yoff;
  logic [8:0]  doy9_nxt, doy9_r;
  logic        leap9_r;
  logic [13:0] yr9_nxt, yr9_r;

  // month walk
  logic [10:0] tm_nxt, tm_r;
  logic [8:0]  doy10_r;
  logic        leap10_r;
  logic [13:0] yr10_r;
  logic [3:0]  mi;
  date_t       date_nxt, date_r;

  always_comb begin
    for (int k = 1; k <= 24; k++) begin
      t400_nxt[k-1] = (day_rebased >= 22'(k * DAYS_400Y));
    end
  end

  assign q400    = 5'(therm_idx(64'(t400_r)));
  assign r3_nxt  = 18'(d2_r - 22'(q400 * DAYS_400Y));
  assign yr3_nxt = 14'(q400 * 400);

  // first century of a cycle is one day longer
  always_comb begin
    for (int k = 1; k <= 3; k++) begin
      tc_nxt[k-1] = (r3_r >= 18'(k * DAYS_100Y + 1));
    end
  end

  // day within century plus one when the century lacks its leading leap day
  assign cent    = 2'(therm_idx(64'(tc_r)));
  assign f5_nxt  = 16'(r4_r - 18'(cent * DAYS_100Y));
  assign yr5_nxt = yr4_r + 14'(cent * 100);

  always_comb begin
    for (int k = 1; k <= 24; k++) begin
      t4_nxt[k-1] = (f5_r >= 16'(k * DAYS_4Y));
    end
  end

  // leading 4-year span of a non-leading century has no leap year
  assign q4         = 5'(therm_idx(64'(t4_r)));
  assign short_span = cnz6_r && (q4 == 5'd0);
  assign rem7_nxt   = short_span ? 11'(f6_r - 16'd1) : 11'(f6_r - 16'(q4 * DAYS_4Y));
  assign yr7_nxt    = yr6_r + 14'(q4 * 4);

  always_comb begin
    for (int k = 1; k <= 3; k++) begin
      ty_nxt[k-1] = (rem7_r >= 11'(k * DAYS_YEAR + (lspan7_r ? 1 : 0)));
    end
  end

  assign yoff     = 2'(therm_idx(64'(ty_r)));
  assign doy9_nxt = 9'(rem8_r - 11'(yoff * DAYS_YEAR)
                       - ((lspan8_r && (yoff != 2'd0)) ? 11'd1 : 11'd0));
  assign yr9_nxt  = yr8_r + 14'(yoff);

  always_comb begin
    for (int m = 1; m <= 11; m++) begin
      tm_nxt[m-1] = (doy9_r >= month_start(4'(m), leap9_r));
    end
  end

  assign mi = 4'(therm_idx(64'(tm_r)));

  always_comb begin
    date_nxt              = '0;
    date_nxt.year         = yr10_r;
    date_nxt.month        = mi + 4'd1;
    date_nxt.day_of_month = 5'(doy10_r - month_start(mi, leap10_r) + 9'd1);
    date_nxt.leap_year    = leap10_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t400_r   <= t400_nxt;
      d2_r     <= day_rebased;
      r3_r     <= r3_nxt;
      yr3_r    <= yr3_nxt;
      tc_r     <= tc_nxt;
      r4_r     <= r3_r;
      yr4_r    <= yr3_r;
      f5_r     <= f5_nxt;
      cnz5_r   <= (cent != 2'd0);
      yr5_r    <= yr5_nxt;
      t4_r     <= t4_nxt;
      f6_r     <= f5_r;
      cnz6_r   <= cnz5_r;
      yr6_r    <= yr5_r;
      rem7_r   <= rem7_nxt;
      lspan7_r <= !short_span;
      yr7_r    <= yr7_nxt;
      ty_r     <= ty_nxt;
      rem8_r   <= rem7_r;
      lspan8_r <= lspan7_r;
      yr8_r    <= yr7_r;
      doy9_r   <= doy9_nxt;
      leap9_r  <= lspan8_r && (yoff == 2'd0);
      yr9_r    <= yr9_nxt;
      tm_r     <= tm_nxt;
      doy10_r  <= doy9_r;
      leap10_r <= leap9_r;
      yr10_r   <= yr9_r;
      date_r   <= date_nxt;
    end
  end

  assign date = date_r;

endmodule

`default_nettype wire

>>> hdl/dsc_time_path.sv
// time-of-day pipeline: milliseconds since midnight to hour, minute, second, millisecond
`default_nettype none

module dsc_time_path (
  input  wire logic          clk,
  input  wire logic          en,
  input  wire logic [26:0]   ms,
  output dsc_pkg::tod_t      tod
);
  import dsc_pkg::*;

  // delay that lines the result up with the date pipeline
  localparam int PAD = 5;

  logic [22:0] th_nxt, th_r;
  logic [26:0] ms2_r;
  logic [4:0]  hour;
  logic [21:0] hrem3_nxt, hrem3_r;
  logic [4:0]  hour3_r;

  logic [58:0] tmin_nxt, tmin_r;
  logic [21:0] hrem4_r;
  logic [4:0]  hour4_r;
  logic [5:0]  minute;
  logic [15:0] mrem5_nxt, mrem5_r;
  logic [5:0]  min5_r;
  logic [4:0]  hour5_r;

  logic [58:0] tsec_nxt, tsec_r;
  logic [15:0] mrem6_r;
  logic [5:0]  min6_r;
  logic [4:0]  hour6_r;
  logic [5:0]  second;
  tod_t        tod7_nxt;
  tod_t        dly_r [PAD];

  always_comb begin
    for (int k = 1; k <= 23; k++) begin
      th_nxt[k-1] = (ms >= 27'(k * MS_PER_HOUR));
    end
  end

  assign hour      = 5'(therm_idx(64'(th_r)));
  assign hrem3_nxt = 22'(ms2_r - 27'(hour * MS_PER_HOUR));

  always_comb begin
    for (int k = 1; k <= 59; k++) begin
      tmin_nxt[k-1] = (hrem3_r >= 22'(k * MS_PER_MINUTE));
    end
  end

  assign minute    = 6'(therm_idx(64'(tmin_r)));
  assign mrem5_nxt = 16'(hrem4_r - 22'(minute * MS_PER_MINUTE));

  always_comb begin
    for (int k = 1; k <= 59; k++) begin
      tsec_nxt[k-1] = (mrem5_r >= 16'(k * MS_PER_SECOND));
    end
  end

  assign second = 6'(therm_idx(64'(tsec_r)));

  always_comb begin
    tod7_nxt             = '0;
    tod7_nxt.hour        = hour6_r;
    tod7_nxt.minute      = min6_r;
    tod7_nxt.second      = second;
    tod7_nxt.millisecond = 10'(mrem6_r - 16'(second * MS_PER_SECOND));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      th_r    <= th_nxt;
      ms2_r   <= ms;
      hrem3_r <= hrem3_nxt;
      hour3_r <= hour;
      tmin_r  <= tmin_nxt;
      hrem4_r <= hrem3_r;
      hour4_r <= hour3_r;
      mrem5_r <= mrem5_nxt;
      min5_r  <= minute;
      hour5_r <= hour4_r;
      tsec_r  <= tsec_nxt;
      mrem6_r <= mrem5_r;
      min6_r  <= min5_r;
      hour6_r <= hour5_r;
      dly_r[0] <= tod7_nxt;
      for (int i = 1; i < PAD; i++) begin
        dly_r[i] <= dly_r[i-1];
      end
    end
  end

  assign tod = dly_r[PAD-1];

endmodule

`default_nettype wire

>>> hdl/dsc_weekday.sv
// day of week pipeline: (day serial + 1) mod 7 by folding octal digits
`default_nettype none

module dsc_weekday (
  input  wire logic          clk,
  input  wire logic          en,
  input  wire logic [21:0]   day_plus1,
  output logic [2:0]         weekday
);
  import dsc_pkg::*;

  // delay that lines the result up with the date pipeline
  localparam int PAD = 9;

  logic [23:0] dz;
  logic [5:0]  wsum_nxt, wsum_r;
  logic [3:0]  fold;
  logic [2:0]  wd_nxt;
  logic [2:0]  dly_r [PAD];

  // 8 = 1 mod 7, so octal digits sum to the same residue
  always_comb begin
    dz       = {2'b00, day_plus1};
    wsum_nxt = '0;
    for (int g = 0; g < 8; g++) begin
      wsum_nxt = wsum_nxt + 6'(dz[3*g +: 3]);
    end
  end

  assign fold   = 4'(wsum_r[5:3]) + 4'(wsum_r[2:0]);
  assign wd_nxt = (fold >= 4'd14) ? 3'(fold - 4'd14) :
                  (fold >= 4'd7)  ? 3'(fold - 4'd7)  : 3'(fold);

  always_ff @(posedge clk) begin
    if (en) begin
      wsum_r   <= wsum_nxt;
      dly_r[0] <= wd_nxt;
      for (int i = 1; i < PAD; i++) begin
        dly_r[i] <= dly_r[i-1];
      end
    end
  end

  assign weekday = dly_r[PAD-1];

endmodule

`default_nettype wire

>>> hdl/day_serial_to_civil_date_unit.sv
// top level of the day serial to civil date and time-of-day converter
//
//  channel | ports                          | payload
//  --------+--------------------------------+-------------------------------------------
//  input   | in_valid, in_ready, in_item    | dsc_in_t: day_number, ms_of_day
//  result  | out_valid, out_ready, out_item | dsc_out_t: date, time, leap, weekday, range
//
// one transaction enters and one result leaves per cycle unless out_ready stalls them
// the path is an entry stage, ten conversion stages, then the output register
// every stage is one bank of constant compares or one small subtract, so nothing iterates
// a stall on the result side freezes all stages at once; nothing is dropped or repeated
// rst_n is synchronous and clears only the valid bits; data registers are not reset
`default_nettype none

module day_serial_to_civil_date_unit (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire dsc_pkg::dsc_in_t   in_item,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output dsc_pkg::dsc_out_t       out_item
);
  import dsc_pkg::*;

  // entry stage plus ten conversion stages
  localparam int DEPTH = 11;

  logic             en;
  logic             oor;
  logic [21:0]      day_z;
  logic [26:0]      ms_z;

  // entry stage registers
  logic [21:0]      d1_r;
  logic [21:0]      wd1_r;
  logic [26:0]      ms1_r;

  // valid and range flags ride along with the data
  logic [DEPTH-1:0] vld_r;
  logic [DEPTH-1:0] oor_r;

  date_t            date;
  tod_t             tod;
  logic [2:0]       weekday;

  dsc_out_t         out_nxt;
  dsc_out_t         out_item_r;
  logic             out_valid_r;

  // whole pipeline moves when the output register is free or being drained
  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  // out of range inputs are replaced by zero so the arithmetic stays in bounds
  assign oor   = (in_item.day_number > 22'(LAST_DAY)) ||
                 (in_item.ms_of_day >= 27'(MS_PER_DAY));
  assign day_z = oor ? '0 : in_item.day_number;
  assign ms_z  = oor ? '0 : in_item.ms_of_day;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[DEPTH-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      oor_r <= {oor_r[DEPTH-2:0], oor};
      d1_r  <= 22'(day_z + 22'(EPOCH_OFFSET));
      wd1_r <= day_z + 22'd1;
      ms1_r <= ms_z;
    end
  end

  dsc_date_path u_date (
    .clk         (clk),
    .en          (en),
    .day_rebased (d1_r),
    .date        (date)
  );

  dsc_time_path u_time (
    .clk (clk),
    .en  (en),
    .ms  (ms1_r),
    .tod (tod)
  );

  dsc_weekday u_wday (
    .clk       (clk),
    .en        (en),
    .day_plus1 (wd1_r),
    .weekday   (weekday)
  );

  // out of range results show zero in every field but the flag
  always_comb begin
    out_nxt = '0;
    if (oor_r[DEPTH-1]) begin
      out_nxt.out_of_range = 1'b1;
    end else begin
      out_nxt.year         = date.year;
      out_nxt.month        = date.month;
      out_nxt.day_of_month = date.day_of_month;
      out_nxt.leap_year    = date.leap_year;
      out_nxt.hour         = tod.hour;
      out_nxt.minute       = tod.minute;
      out_nxt.second       = tod.second;
      out_nxt.millisecond  = tod.millisecond;
      out_nxt.weekday      = weekday;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= vld_r[DEPTH-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_item_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // flagged results carry zero in the year, month, day of month and leap fields
  a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.out_of_range |->
      out_item.year == 14'd0 && out_item.month == 4'd0 &&
      out_item.day_of_month == 5'd0 && out_item.leap_year == 1'b0)
    else $error("out of range result carries date fields");

  // month lies in 1 to 12, day of month is at least 1 and at most 29 in february, and the year is at least 1900
  a_date_span: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.out_of_range |->
      out_item.month >= 4'd1 && out_item.month <= 4'd12 &&
      out_item.day_of_month >= 5'd1 && out_item.year >= 14'd1900 &&
      (out_item.month != 4'd2 || out_item.day_of_month <= 5'd29))
    else $error("date fields out of span");

  // leap flag only on years divisible by four
  a_leap_year: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.leap_year |-> out_item.year[1:0] == 2'd0)
    else $error("leap flag on a year not divisible by four");

  // time fields and weekday stay within their spans
  a_tod_span: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |->
      out_item.hour <= 5'd23 && out_item.minute <= 6'd59 &&
      out_item.second <= 6'd59 && out_item.millisecond <= 10'd999 &&
      out_item.weekday <= 3'd6)
    else $error("time of day or weekday out of span");

endmodule

`default_nettype wire
